// ===== rtl/talp_pkg.sv =====
// talp_pkg: shared constants, codes, types and the LED pattern function
// for the tilt_average_led_pwm block. No dependencies.
package talp_pkg;

  localparam int WINDOW_DEF      = 10;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int OFS_W      = 10;
  localparam int PWM_W      = 5;
  localparam int LEVEL_W    = 5;
  localparam int LED_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [OFS_W-1:0] OFS_RESET     = 10'h3E0;  // -32
  localparam logic [PWM_W-1:0] PWM_TOP_RESET = 5'd16;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILT_OFFSET = 1'b0,
    CFG_PWM_TOP     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // low 8 bits of (8 >> v) | (8 << (8 - v))
  function automatic logic [LED_W-1:0] pattern_of(input logic [2:0] v);
    logic [15:0] wide;
    wide = (16'd8 >> v) | (16'd8 << (4'd8 - {1'b0, v}));
    return wide[LED_W-1:0];
  endfunction

endpackage

// ===== rtl/talp_front.sv =====
// talp_front: accepts input items, keeps the sample delay lines and running sums,
// and pushes each item with the current window sums into the queue.
// Depends on talp_pkg.
module talp_front #(
  parameter int WINDOW      = talp_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = talp_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW),
  parameter int ENT_W       = 1 + 2 * SUM_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_op,
  input  logic [SAMPLE_BITS-1:0] in_sample_x,
  input  logic [SAMPLE_BITS-1:0] in_sample_y,
  input  talp_pkg::q_status_t    q_status,
  output logic                   push,
  output logic [ENT_W-1:0]       push_data
);

  localparam int EXT_W = SUM_W - SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] x_hist_r [WINDOW];
  logic [SAMPLE_BITS-1:0] y_hist_r [WINDOW];
  logic [SUM_W-1:0]       sum_x_r;
  logic [SUM_W-1:0]       sum_y_r;
  logic [SUM_W-1:0]       sum_x_nxt;
  logic [SUM_W-1:0]       sum_y_nxt;
  logic                   accept;
  logic                   is_sample;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign is_sample = (in_op == talp_pkg::OP_SAMPLE);

  assign sum_x_nxt = sum_x_r
                   + {{EXT_W{in_sample_x[SAMPLE_BITS-1]}}, in_sample_x}
                   - {{EXT_W{x_hist_r[WINDOW-1][SAMPLE_BITS-1]}}, x_hist_r[WINDOW-1]};
  assign sum_y_nxt = sum_y_r
                   + {{EXT_W{in_sample_y[SAMPLE_BITS-1]}}, in_sample_y}
                   - {{EXT_W{y_hist_r[WINDOW-1][SAMPLE_BITS-1]}}, y_hist_r[WINDOW-1]};

  assign push      = accept;
  assign push_data = is_sample ? {in_op, sum_x_nxt, sum_y_nxt}
                               : {in_op, sum_x_r, sum_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        x_hist_r[i] <= '0;
        y_hist_r[i] <= '0;
      end
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (accept && is_sample) begin
      for (int i = 1; i < WINDOW; i++) begin
        x_hist_r[i] <= x_hist_r[i-1];
        y_hist_r[i] <= y_hist_r[i-1];
      end
      x_hist_r[0] <= in_sample_x;
      y_hist_r[0] <= in_sample_y;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
    end
  end

endmodule

// ===== rtl/talp_queue.sv =====
// talp_queue: short FIFO between the front and back parts.
// Depends on talp_pkg for the status type and the default depth.
module talp_queue #(
  parameter int ENT_W = 8,
  parameter int DEPTH = talp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [ENT_W-1:0]    push_data,
  input  logic                pop,
  output logic [ENT_W-1:0]    pop_data,
  output talp_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ENT_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/talp_back.sv =====
// talp_back: divides window sums by WINDOW (reciprocal multiply, split in two
// partial products), maps x to LED pattern and level, runs the PWM counter,
// holds the configuration registers and the output register. Depends on talp_pkg.
module talp_back #(
  parameter int WINDOW      = talp_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = talp_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW),
  parameter int ENT_W       = 1 + 2 * SUM_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [talp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [talp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  talp_pkg::q_status_t               q_status,
  output logic                              pop,
  input  logic [ENT_W-1:0]                  pop_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_kind,
  output logic [SAMPLE_BITS-1:0]            out_avg_x,
  output logic [SAMPLE_BITS-1:0]            out_avg_y,
  output logic [talp_pkg::LED_W-1:0]        out_led_out
);

  localparam int OFS_W   = talp_pkg::OFS_W;
  localparam int PWM_W   = talp_pkg::PWM_W;
  localparam int LEVEL_W = talp_pkg::LEVEL_W;
  localparam int LED_W   = talp_pkg::LED_W;

  localparam int MAG_W   = SUM_W;
  localparam int SHIFT   = MAG_W + $clog2(WINDOW);
  localparam int M_W     = MAG_W + 1;
  localparam int M_LO_W  = M_W / 2;
  localparam int M_HI_W  = M_W - M_LO_W;
  localparam int PP_LO_W = MAG_W + M_LO_W;
  localparam int PP_HI_W = MAG_W + M_HI_W;
  localparam int PROD_W  = MAG_W + M_W;
  localparam int S_W     = ((SAMPLE_BITS > OFS_W) ? SAMPLE_BITS : OFS_W) + 1;

  localparam logic [63:0]     RECIP64 = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1)
                                        / 64'(WINDOW);
  localparam logic [M_W-1:0]    RECIP = RECIP64[M_W-1:0];
  localparam logic [M_LO_W-1:0] M_LO  = RECIP[M_LO_W-1:0];
  localparam logic [M_HI_W-1:0] M_HI  = RECIP[M_W-1:M_LO_W];

  // config
  logic [OFS_W-1:0]   tilt_offset_r;
  logic [PWM_W-1:0]   pwm_top_r;

  // queue head
  logic               q_op;
  logic [SUM_W-1:0]   q_sum_x;
  logic [SUM_W-1:0]   q_sum_y;
  logic [MAG_W-1:0]   mag_x;
  logic [MAG_W-1:0]   mag_y;
  logic               adv;

  // stage A: partial products
  logic               a_vld_r;
  logic               a_op_r;
  logic               a_neg_x_r;
  logic               a_neg_y_r;
  logic [PP_LO_W-1:0] a_pplo_x_r;
  logic [PP_HI_W-1:0] a_pphi_x_r;
  logic [PP_LO_W-1:0] a_pplo_y_r;
  logic [PP_HI_W-1:0] a_pphi_y_r;

  // stage B: averages
  logic [PROD_W-1:0]      prod_x;
  logic [PROD_W-1:0]      prod_y;
  logic [SAMPLE_BITS-1:0] quo_x;
  logic [SAMPLE_BITS-1:0] quo_y;
  logic [SAMPLE_BITS-1:0] avg_x_nxt;
  logic [SAMPLE_BITS-1:0] avg_y_nxt;
  logic                   b_vld_r;
  logic                   b_op_r;
  logic [SAMPLE_BITS-1:0] b_avg_x_r;
  logic [SAMPLE_BITS-1:0] b_avg_y_r;

  // stage C: LED state and output register
  logic [S_W-1:0]         tilt_sum;
  logic [LED_W-1:0]       pattern_r;
  logic [LEVEL_W-1:0]     level_r;
  logic [PWM_W-1:0]       pwm_r;
  logic [LED_W-1:0]       led_nxt;
  logic [PWM_W-1:0]       pwm_nxt;
  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [SAMPLE_BITS-1:0] out_avg_x_r;
  logic [SAMPLE_BITS-1:0] out_avg_y_r;
  logic [LED_W-1:0]       out_led_r;

  assign q_op    = pop_data[ENT_W-1];
  assign q_sum_x = pop_data[2*SUM_W-1:SUM_W];
  assign q_sum_y = pop_data[SUM_W-1:0];
  assign mag_x   = q_sum_x[SUM_W-1] ? (~q_sum_x + 1'b1) : q_sum_x;
  assign mag_y   = q_sum_y[SUM_W-1] ? (~q_sum_y + 1'b1) : q_sum_y;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !q_status.empty;

  assign prod_x    = (PROD_W'(a_pphi_x_r) << M_LO_W) + PROD_W'(a_pplo_x_r);
  assign prod_y    = (PROD_W'(a_pphi_y_r) << M_LO_W) + PROD_W'(a_pplo_y_r);
  assign quo_x     = prod_x[SHIFT +: SAMPLE_BITS];
  assign quo_y     = prod_y[SHIFT +: SAMPLE_BITS];
  assign avg_x_nxt = a_neg_x_r ? (~quo_x + 1'b1) : quo_x;
  assign avg_y_nxt = a_neg_y_r ? (~quo_y + 1'b1) : quo_y;

  assign tilt_sum = {{(S_W - SAMPLE_BITS){b_avg_x_r[SAMPLE_BITS-1]}}, b_avg_x_r}
                  + {{(S_W - OFS_W){tilt_offset_r[OFS_W-1]}}, tilt_offset_r};

  assign led_nxt = (pwm_r < level_r) ? (pattern_r >> 1) : pattern_r;
  assign pwm_nxt = (pwm_r > pwm_top_r) ? '0 : pwm_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_offset_r <= talp_pkg::OFS_RESET;
      pwm_top_r     <= talp_pkg::PWM_TOP_RESET;
    end else if (cfg_valid) begin
      case (talp_pkg::cfg_reg_t'(cfg_index))
        talp_pkg::CFG_TILT_OFFSET: tilt_offset_r <= cfg_data[OFS_W-1:0];
        talp_pkg::CFG_PWM_TOP:     pwm_top_r     <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r     <= q_op;
      a_neg_x_r  <= q_sum_x[SUM_W-1];
      a_neg_y_r  <= q_sum_y[SUM_W-1];
      a_pplo_x_r <= PP_LO_W'(mag_x) * PP_LO_W'(M_LO);
      a_pphi_x_r <= PP_HI_W'(mag_x) * PP_HI_W'(M_HI);
      a_pplo_y_r <= PP_LO_W'(mag_y) * PP_LO_W'(M_LO);
      a_pphi_y_r <= PP_HI_W'(mag_y) * PP_HI_W'(M_HI);
      b_op_r     <= a_op_r;
      b_avg_x_r  <= avg_x_nxt;
      b_avg_y_r  <= avg_y_nxt;
      if (b_vld_r) begin
        out_kind_r  <= b_op_r;
        out_avg_x_r <= b_avg_x_r;
        out_avg_y_r <= b_avg_y_r;
        out_led_r   <= (b_op_r == talp_pkg::OP_TICK) ? led_nxt : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pattern_r   <= '0;
      level_r     <= '0;
      pwm_r       <= '0;
    end else if (adv) begin
      a_vld_r     <= !q_status.empty;
      b_vld_r     <= a_vld_r;
      out_valid_r <= b_vld_r;
      if (b_vld_r) begin
        if (b_op_r == talp_pkg::OP_TICK) begin
          pwm_r <= pwm_nxt;
        end else begin
          pattern_r <= talp_pkg::pattern_of(tilt_sum[8:6]);
          level_r   <= tilt_sum[5:1];
        end
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_avg_x   = out_avg_x_r;
  assign out_avg_y   = out_avg_y_r;
  assign out_led_out = out_led_r;

endmodule

// ===== rtl/tilt_average_led_pwm.sv =====
// tilt_average_led_pwm: top level; front part, queue and back part.
// Depends on talp_pkg, talp_front, talp_queue and talp_back.
//
// Takes one item per clock while in_stall is low: a sample (op 0) updates the
// WINDOW-deep x/y running sums, a tick (op 1) emits the LED pattern, dimmed by
// shifting right while the PWM counter is below the level. Every item gives
// exactly one result, through the queue, stages A and B and the output register;
// averages are the window sums divided by WINDOW and truncated toward zero,
// done with a reciprocal multiply split over two partial products. A four-entry
// queue sits between the front and the back, so in_stall rises only after
// out_stall has held the result pipeline long enough to fill it. Configuration
// writes are always ready and should be made while no item is in flight.
module tilt_average_led_pwm #(
  parameter int WINDOW      = talp_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = talp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [SAMPLE_BITS-1:0]          in_sample_x,
  input  logic [SAMPLE_BITS-1:0]          in_sample_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic [SAMPLE_BITS-1:0]          out_avg_x,
  output logic [SAMPLE_BITS-1:0]          out_avg_y,
  output logic [talp_pkg::LED_W-1:0]      out_led_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [talp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [talp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
  localparam int ENT_W = 1 + 2 * SUM_W;

  talp_pkg::q_status_t q_status;
  logic                push;
  logic [ENT_W-1:0]    push_data;
  logic                pop;
  logic [ENT_W-1:0]    pop_data;

  assign cfg_ready = 1'b1;

  talp_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .ENT_W       (ENT_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_sample_x (in_sample_x),
    .in_sample_y (in_sample_y),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  talp_queue #(
    .ENT_W (ENT_W),
    .DEPTH (talp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  talp_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .ENT_W       (ENT_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_status    (q_status),
    .pop         (pop),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_avg_x   (out_avg_x),
    .out_avg_y   (out_avg_y),
    .out_led_out (out_led_out)
  );

endmodule
